### hdl/assert_macros.svh
// Assertion macros used by the deframer top level.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("deframer check failed");
// Antecedent implies consequent in the same cycle.
`define WSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer implication failed");
// Antecedent implies consequent in the following cycle.
`define WSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer sequence failed");
`else
`define WSD_ASSERT(lbl, clk, rstn, prop)
`define WSD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WSD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every deframer module.
`default_nettype none

package wsd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXT,
        PH_KEY,
        PH_DATA,
        PH_HALT
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_BADLEN = 2'd2;

    // Header codes
    localparam logic [3:0] OPC_CLOSE   = 4'h8;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd4096;

    // One classified byte handed from parser to output stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] raw;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       last;
    } qent_t;

    // Parser status seen by the top level
    typedef struct packed {
        logic push;
        logic halted;
    } front_stat_t;

endpackage

`default_nettype wire

### hdl/websocket_frame_deframer_top.sv
// A transferred byte's result is written into the queue, then loaded into the output register (out_valid).
// Throughput: one byte per cycle; in_ready falls only when the queue between the
// parser and the output register fills under sustained out_ready low.
// Header and key bytes make no result, but a close opcode or a bad length does; after either, all bytes are dropped.
// Reset (rst_n, async low) returns to the first header byte, empties the queue and
// sets max_payload to 4096.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [3:0]       frame_opcode,
    output logic             last_byte
);
    import wsd_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH) + 1;

    qent_t        front_ent;
    qent_t        back_ent;
    front_stat_t  stat;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;
    logic [LW-1:0] q_level;
    logic         in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_xfer   = in_valid && in_ready;

    wsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .accept   (in_xfer),
        .rx_byte  (rx_byte),
        .ent      (front_ent),
        .stat     (stat)
    );

    wsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (stat.push),
        .wr_ent (front_ent),
        .pop    (q_pop),
        .rd_ent (back_ent),
        .full   (q_full),
        .empty  (q_empty),
        .level  (q_level)
    );

    wsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ent          (back_ent),
        .empty        (q_empty),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_opcode (frame_opcode),
        .last_byte    (last_byte)
    );

    // Checks
    `WSD_ASSERT(a_level_bound, clk, rst_n, q_level <= QUEUE_DEPTH[LW-1:0])
    `WSD_ASSERT_IMP(a_halt_quiet, clk, rst_n, stat.halted, !stat.push)
    `WSD_ASSERT_NXT(a_status_halts, clk, rst_n, stat.push && front_ent.kind != KIND_DATA, stat.halted)
    `WSD_ASSERT_IMP(a_status_clean, clk, rst_n, out_valid && kind != KIND_DATA, data_byte == 8'd0 && !last_byte)

endmodule

`default_nettype wire

### hdl/wsd_front.sv
// Header parser: accepts stream bytes, tracks frame state, classifies each byte.
// Depends on wsd_pkg; feeds wsd_fifo.
`default_nettype none

module wsd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    output wsd_pkg::qent_t     ent,
    output wsd_pkg::front_stat_t stat
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [3:0]  ext_reg, ext_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] max_reg;

    logic        push;
    logic        chk;
    logic [63:0] len_chk;
    logic [7:0]  key_sel;
    logic [6:0]  code;
    logic        bad;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= MAX_PAYLOAD_RST;
        else if (cfg_we)
            max_reg <= cfg_data;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
            ext_reg    <= 4'd0;
            len_reg    <= 64'd0;
            key_reg    <= 32'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            ext_reg    <= ext_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

    // Current key byte, first key byte in the top bits
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    assign code = rx_byte[6:0];
    // Length check: zero, or at/above the limit (upper word nonzero always exceeds)
    assign bad  = (len_chk == 64'd0) || (len_chk[63:32] != 32'd0) || (len_chk[31:0] >= max_reg);

    // Next state and classification
    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        ext_next    = ext_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        push        = 1'b0;
        chk         = 1'b0;
        len_chk     = 64'd0;
        ent         = '0;
        ent.opcode  = opcode_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    opcode_next = rx_byte[3:0];
                    if (rx_byte[3:0] == OPC_CLOSE)
                    begin
                        phase_next = PH_HALT;
                        push       = 1'b1;
                        ent.kind   = KIND_CLOSE;
                        ent.opcode = OPC_CLOSE;
                    end
                    else
                        phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    masked_next = rx_byte[7];
                    key_next    = 32'd0;
                    if (code == LEN_EXT16 || code == LEN_EXT64)
                    begin
                        ext_next   = (code == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        len_next   = 64'd0;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        len_chk  = {57'd0, code};
                        len_next = len_chk;
                        chk      = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    // Big-endian accumulate
                    len_chk  = {len_reg[55:0], rx_byte};
                    len_next = len_chk;
                    ext_next = ext_reg - 4'd1;
                    if (ext_next == 4'd0)
                        chk = 1'b1;
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    push      = 1'b1;
                    ent.kind  = KIND_DATA;
                    ent.raw   = rx_byte;
                    ent.key   = masked_reg ? key_sel : 8'd0;
                    idx_next  = idx_reg + 2'd1;
                    len_next  = len_reg - 64'd1;
                    ent.last  = (len_next == 64'd0);
                    if (len_next == 64'd0)
                        phase_next = PH_HDR1;
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase

            // Length fully known
            if (chk)
            begin
                if (bad)
                begin
                    phase_next = PH_HALT;
                    push       = 1'b1;
                    ent.kind   = KIND_BADLEN;
                end
                else
                begin
                    idx_next   = 2'd0;
                    phase_next = masked_next ? PH_KEY : PH_DATA;
                end
            end
        end
    end

    assign stat.push   = push;
    assign stat.halted = (phase_reg == PH_HALT);

endmodule

`default_nettype wire

### hdl/wsd_fifo.sv
// Short queue of classified bytes between parser and output stage.
// Depends on wsd_pkg for the entry type.
`default_nettype none

module wsd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire wsd_pkg::qent_t wr_ent,
    input  wire logic           pop,
    output wsd_pkg::qent_t      rd_ent,
    output logic                full,
    output logic                empty,
    output logic [$clog2(DEPTH):0] level
);
    import wsd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    qent_t        mem [DEPTH];
    logic [AW:0]  wr_ptr_reg;
    logic [AW:0]  rd_ptr_reg;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg[AW-1:0]] <= wr_ent;
    end

    // Pointers carry a wrap bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    assign level  = wr_ptr_reg - rd_ptr_reg;
    assign full   = (level == DEPTH[AW:0]);
    assign empty  = (wr_ptr_reg == rd_ptr_reg);
    assign rd_ent = mem[rd_ptr_reg[AW-1:0]];

endmodule

`default_nettype wire

### hdl/wsd_back.sv
// Output stage: unmasks queued bytes and holds the result register.
// Depends on wsd_pkg; drains wsd_fifo.
`default_nettype none

module wsd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire wsd_pkg::qent_t ent,
    input  wire logic           empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          kind,
    output logic [7:0]          data_byte,
    output logic [3:0]          frame_opcode,
    output logic                last_byte
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] data_reg;
    logic [3:0] opc_reg;
    logic       last_reg;

    // Load when the register is free or being drained this cycle
    assign pop = !empty && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // Payload register, unmask on the way in
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= ent.kind;
            data_reg <= ent.raw ^ ent.key;
            opc_reg  <= ent.opcode;
            last_reg <= ent.last;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign frame_opcode = opc_reg;
    assign last_byte    = last_reg;

endmodule

`default_nettype wire
